// ===== hw/rtl/brbdma_pkg.sv =====
// ----------------------------------------------------------------------------
// brbdma_pkg
// Shared types and constants for the circular byte FIFO with DMA head.
// ----------------------------------------------------------------------------
package brbdma_pkg;

	// Pointer geometry: pointers are bytes, the size in use is at most 256
	localparam int unsigned PTR_W     = 8;
	localparam int unsigned PTR_SPAN  = 256;
	localparam int unsigned DEPTH_DEF = 256;

	// Size register limits
	localparam int unsigned SZ_W      = 4;
	localparam logic [3:0]  SZ_MIN    = 4'd1;
	localparam logic [3:0]  SZ_MAX    = 4'd8;
	localparam logic [3:0]  SZ_RESET  = 4'd8;

	// Configuration port
	localparam int unsigned APB_AW    = 3;
	localparam int unsigned APB_DW    = 32;
	localparam logic        REG_DMA_MODE  = 1'b0;
	localparam logic        REG_SIZE_LOG2 = 1'b1;

	// Item commands
	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_SKIP   = 2'd2,
		CMD_STATUS = 2'd3
	} cmd_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take;    // latch the input transaction
		logic exec;    // evaluate the item, update pointers and storage
		logic fetch;   // read the result byte from storage
		logic load;    // move the result into the output register
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free; // output register can take a result this cycle
	} dp_stat_t;

endpackage

// ===== hw/rtl/brbdma_ctrl.sv =====
// ----------------------------------------------------------------------------
// brbdma_ctrl
// Sequencer: accept, execute, storage fetch, output load.
// ----------------------------------------------------------------------------
module brbdma_ctrl
	import brbdma_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EXEC  = 4'b0010,
		ST_FETCH = 4'b0100,
		ST_LOAD  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_EXEC;
			ST_EXEC:  state_d = ST_FETCH;
			ST_FETCH: state_d = ST_LOAD;
			ST_LOAD:  if (stat.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands to the datapath
	assign in_stall  = (state_q != ST_IDLE);
	assign cmd.take  = (state_q == ST_IDLE) && in_valid;
	assign cmd.exec  = (state_q == ST_EXEC);
	assign cmd.fetch = (state_q == ST_FETCH);
	assign cmd.load  = (state_q == ST_LOAD) && stat.out_free;

endmodule

// ===== hw/rtl/brbdma_dp.sv =====
// ----------------------------------------------------------------------------
// brbdma_dp
// Datapath: pointers, byte storage, fill and run arithmetic, output register.
// ----------------------------------------------------------------------------
module brbdma_dp
	import brbdma_pkg::*;
#(
	parameter int unsigned MAX_DEPTH = DEPTH_DEF
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  logic             dma_mode,
	input  logic [SZ_W-1:0]  size_log2,
	input  logic [1:0]       in_cmd,
	input  logic [PTR_W-1:0] in_data,
	input  logic [PTR_W-1:0] in_skip,
	input  logic [PTR_W-1:0] in_head,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [PTR_W-1:0] out_data,
	output logic             out_done,
	output logic [PTR_W-1:0] out_moved,
	output logic [PTR_W-1:0] out_fill,
	output logic [PTR_W-1:0] out_contig
);

	localparam int unsigned AW = $clog2(MAX_DEPTH);

	// Pointer to storage slot, pointer taken modulo the storage depth
	typedef logic [AW-1:0] slot_tbl_t [PTR_SPAN];

	function automatic slot_tbl_t build_slots();
		slot_tbl_t   t;
		int unsigned r;
		r = 0;
		for (int i = 0; i < PTR_SPAN; i++) begin
			t[i] = AW'(r);
			r    = (r == MAX_DEPTH - 1) ? 0 : r + 1;
		end
		return t;
	endfunction

	localparam slot_tbl_t SLOT_TBL = build_slots();

	// Storage
	logic [PTR_W-1:0] mem_q [MAX_DEPTH];

	// Latched transaction
	cmd_t             cmd_q;
	logic [PTR_W-1:0] din_q;
	logic [PTR_W-1:0] slen_q;
	logic [PTR_W-1:0] dhead_q;

	// Pointers and per-item results
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] rdata_q;
	logic             zero_q;
	logic             done_q;
	logic [PTR_W-1:0] moved_q;
	logic [PTR_W-1:0] fill_q;
	logic [PTR_W-1:0] contig_q;

	// Output register
	logic             ovld_q;
	logic [PTR_W-1:0] odata_q;
	logic             odone_q;
	logic [PTR_W-1:0] omoved_q;
	logic [PTR_W-1:0] ofill_q;
	logic [PTR_W-1:0] ocontig_q;

	// Item evaluation
	logic [SZ_W-1:0]  lg;
	logic [PTR_W:0]   size;
	logic [PTR_W-1:0] mask;
	logic [PTR_W-1:0] tail;
	logic [PTR_W-1:0] head;
	logic [PTR_W-1:0] count;
	logic             wr_ok;
	logic             rd_ok;
	logic             is_skip;
	logic [PTR_W-1:0] moved;
	logic [PTR_W-1:0] head_nx;
	logic [PTR_W-1:0] tail_nx;
	logic [PTR_W-1:0] fill_nx;
	logic [PTR_W:0]   to_end;
	logic [PTR_W-1:0] contig_nx;

	// Clamp the size and derive the mask
	always_comb begin
		if (size_log2 < SZ_MIN) begin
			lg = SZ_MIN;
		end else if (size_log2 > SZ_MAX) begin
			lg = SZ_MAX;
		end else begin
			lg = size_log2;
		end
		size = (PTR_W+1)'(1) << lg;
		mask = PTR_W'(size - (PTR_W+1)'(1));
	end

	// Decide the item and the pointers after it
	always_comb begin
		tail    = tail_q & mask;
		head    = (dma_mode ? dhead_q : head_q) & mask;
		count   = (head - tail) & mask;
		wr_ok   = (cmd_q == CMD_WRITE) && !dma_mode && (count < mask);
		rd_ok   = (cmd_q == CMD_READ) && (count != '0);
		is_skip = (cmd_q == CMD_SKIP);
		if (wr_ok || rd_ok) begin
			moved = PTR_W'(1);
		end else if (is_skip) begin
			moved = (slen_q > count) ? count : slen_q;
		end else begin
			moved = '0;
		end
		head_nx   = wr_ok ? ((head + PTR_W'(1)) & mask) : head;
		tail_nx   = (rd_ok || is_skip) ? ((tail + moved) & mask) : tail;
		fill_nx   = (head_nx - tail_nx) & mask;
		to_end    = size - {1'b0, tail_nx};
		contig_nx = ({1'b0, fill_nx} <= to_end) ? fill_nx : PTR_W'(to_end);
	end

	// Latch the transaction
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cmd_q   <= cmd_t'(in_cmd);
			din_q   <= in_data;
			slen_q  <= in_skip;
			dhead_q <= in_head;
		end
	end

	// Advance the pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (cmd.exec) begin
			if (wr_ok) begin
				head_q <= head_nx;
			end
			if (rd_ok || is_skip) begin
				tail_q <= tail_nx;
			end
		end
	end

	// Hold the item results
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_ptr_q <= rd_ok ? tail : tail_nx;
			zero_q   <= !rd_ok && (fill_nx == '0);
			done_q   <= wr_ok || rd_ok;
			moved_q  <= moved;
			fill_q   <= fill_nx;
			contig_q <= contig_nx;
		end
	end

	// Storage write on execute, registered read on fetch
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_ok) begin
			mem_q[SLOT_TBL[head]] <= din_q;
		end
		if (cmd.fetch) begin
			rdata_q <= mem_q[SLOT_TBL[rd_ptr_q]];
		end
	end

	// Output register
	assign stat.out_free = !ovld_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (cmd.load) begin
			ovld_q <= 1'b1;
		end else if (!out_stall) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			odata_q   <= zero_q ? '0 : rdata_q;
			odone_q   <= done_q;
			omoved_q  <= moved_q;
			ofill_q   <= fill_q;
			ocontig_q <= contig_q;
		end
	end

	assign out_valid  = ovld_q;
	assign out_data   = odata_q;
	assign out_done   = odone_q;
	assign out_moved  = omoved_q;
	assign out_fill   = ofill_q;
	assign out_contig = ocontig_q;

endmodule

// ===== hw/rtl/byte_ring_buffer_with_dma_head_unit.sv =====
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_dma_head_unit
// Circular byte FIFO, power-of-two size in use, one slot kept free, head
// from software or from a DMA engine.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   input   | in        | in_valid/in_stall  | cmd, data_in, skip_len, dma_head
//   result  | out       | out_valid/out_stall| data_out, done_res, moved,
//           |           |                    | fill_count, contiguous
//   config  | in        | APB psel/penable   | dma_mode, size_log2
//
// An item goes through four steps in order: accept, execute (pointer update
// and storage write), storage read, output load. The next item is accepted
// while a result waits in the output register. A stalled output holds the
// sequencer in its load step until the register frees. Reset clears the
// pointers, configuration and output valid flag, not storage or data latches.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_dma_head_unit
	import brbdma_pkg::*;
#(
	parameter int unsigned MAX_DEPTH = DEPTH_DEF
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [PTR_W-1:0]  data_in,
	input  logic [PTR_W-1:0]  skip_len,
	input  logic [PTR_W-1:0]  dma_head,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PTR_W-1:0]  data_out,
	output logic              done_res,
	output logic [PTR_W-1:0]  moved,
	output logic [PTR_W-1:0]  fill_count,
	output logic [PTR_W-1:0]  contiguous,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic            dma_mode_q;
	logic [SZ_W-1:0] size_log2_q;
	logic            cfg_wr;
	dp_cmd_t         dcmd;
	dp_stat_t        dstat;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dma_mode_q  <= 1'b0;
			size_log2_q <= SZ_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_DMA_MODE) begin
				dma_mode_q <= pwdata[0];
			end else begin
				size_log2_q <= pwdata[SZ_W-1:0];
			end
		end
	end

	// Register readback
	always_comb begin
		if (paddr[2] == REG_SIZE_LOG2) begin
			prdata = APB_DW'(size_log2_q);
		end else begin
			prdata = APB_DW'(dma_mode_q);
		end
	end

	brbdma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (dstat),
		.cmd      (dcmd)
	);

	brbdma_dp #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dcmd),
		.stat       (dstat),
		.dma_mode   (dma_mode_q),
		.size_log2  (size_log2_q),
		.in_cmd     (cmd),
		.in_data    (data_in),
		.in_skip    (skip_len),
		.in_head    (dma_head),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (data_out),
		.out_done   (done_res),
		.out_moved  (moved),
		.out_fill   (fill_count),
		.out_contig (contiguous)
	);

endmodule
